### sv/url_percent_decoder_macros.svh
// ---------------------------------------------------------------------------
// URL percent decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and off while in reset.
// ---------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Same-cycle implication.
`define UPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/upd_pkg.sv
// ---------------------------------------------------------------------------
// URL percent decoder package
// Types, constants and the hex digit helper shared by the decoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Capacity register reset value.
    localparam logic [15:0] CAPACITY_RESET = 16'd512;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PHASE_NORMAL = 2'd0,
        PHASE_HIGH   = 2'd1,
        PHASE_LOW    = 2'd2,
        PHASE_DROP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] out_position;
        logic        is_end;
    } result_t;

    // Up to two results produced by one decoded byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } emit_t;

    // Queue status toward the decoder.
    typedef struct packed {
        logic           room;
        logic [QCW-1:0] level;
    } qstat_t;

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = c[3:0] + 4'd9;
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/upd_in_stage.sv
// ---------------------------------------------------------------------------
// URL percent decoder input stage
// Registers one source beat and holds it until the decoder takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upd_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       take,
    output logic            stage_valid,
    output logic [7:0]      stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // The stage is free when empty or when its beat leaves this cycle.
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
            byte_reg <= in_byte;
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

endmodule

`default_nettype wire

### sv/upd_decode.sv
// ---------------------------------------------------------------------------
// URL percent decoder core
// Escape state machine, capacity check and output position counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upd_decode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          stage_valid,
    input  wire logic [7:0]    stage_byte,
    input  wire upd_pkg::qstat_t qstat,
    output logic               take,
    output upd_pkg::emit_t     emit
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      nibble_reg, nibble_next;
    logic [15:0]     count_reg, count_next;
    logic [15:0]     cap_reg;
    logic [16:0]     count_plus1;
    logic            full;
    logic [3:0]      digit;
    logic [3:0]      end_hi;
    logic [1:0]      n;
    upd_pkg::result_t r0, r1;

    assign take        = stage_valid && qstat.room;
    assign count_plus1 = {1'b0, count_reg} + 17'd1;
    assign full        = count_plus1 >= {1'b0, cap_reg};
    assign digit       = upd_pkg::hex_value(stage_byte);
    assign end_hi      = (phase_reg == upd_pkg::PHASE_LOW) ? nibble_reg : 4'd0;

    // Next state and results for the beat in the input stage.
    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        count_next  = count_reg;
        n           = 2'd0;
        r0          = '{out_byte: 8'd0, out_position: count_reg, is_end: 1'b0};
        r1          = '{out_byte: 8'd0, out_position: count_plus1[15:0], is_end: 1'b1};
        if (stage_byte == upd_pkg::CHAR_NUL) begin
            // End of string: flush an open escape, then the terminator.
            if (phase_reg == upd_pkg::PHASE_HIGH || phase_reg == upd_pkg::PHASE_LOW) begin
                r0.out_byte = {end_hi, 4'd0};
                n           = 2'd2;
            end else begin
                r0.is_end = 1'b1;
                n         = 2'd1;
            end
            phase_next  = upd_pkg::PHASE_NORMAL;
            nibble_next = 4'd0;
            count_next  = 16'd0;
        end else begin
            case (phase_reg)
                upd_pkg::PHASE_HIGH:
                begin
                    nibble_next = digit;
                    phase_next  = upd_pkg::PHASE_LOW;
                end
                upd_pkg::PHASE_LOW:
                begin
                    r0.out_byte = {nibble_reg, digit};
                    n           = 2'd1;
                    count_next  = count_plus1[15:0];
                    nibble_next = 4'd0;
                    phase_next  = upd_pkg::PHASE_NORMAL;
                end
                upd_pkg::PHASE_DROP:
                begin
                    phase_next = upd_pkg::PHASE_DROP;
                end
                default:
                begin
                    if (full) begin
                        phase_next = upd_pkg::PHASE_DROP;
                    end else if (stage_byte == upd_pkg::CHAR_PERCENT) begin
                        nibble_next = 4'd0;
                        phase_next  = upd_pkg::PHASE_HIGH;
                    end else begin
                        r0.out_byte = (stage_byte == upd_pkg::CHAR_PLUS) ?
                                      upd_pkg::CHAR_SPACE : stage_byte;
                        n           = 2'd1;
                        count_next  = count_plus1[15:0];
                    end
                end
            endcase
        end
    end

    assign emit = '{count: take ? n : 2'd0, r0: r0, r1: r1};

    // Decoder state advances only when a beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= upd_pkg::PHASE_NORMAL;
            nibble_reg <= 4'd0;
            count_reg  <= 16'd0;
        end else if (take) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            count_reg  <= count_next;
        end
    end

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= upd_pkg::CAPACITY_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

endmodule

`default_nettype wire

### sv/upd_out_queue.sv
// ---------------------------------------------------------------------------
// URL percent decoder result queue
// Shifting queue of result registers: up to two beats in, one beat out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upd_out_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire upd_pkg::emit_t  emit,
    output upd_pkg::qstat_t      qstat,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output upd_pkg::result_t     head
);

    upd_pkg::result_t slot_reg  [upd_pkg::QDEPTH];
    upd_pkg::result_t slot_next [upd_pkg::QDEPTH];
    logic [upd_pkg::QCW-1:0] level_reg, level_next;
    logic [upd_pkg::QCW-1:0] base;
    logic                    pop;

    assign out_valid = (level_reg != '0);
    assign pop       = out_valid && out_ready;
    assign base      = level_reg - {{(upd_pkg::QCW-1){1'b0}}, pop};
    assign head      = slot_reg[0];

    // Room for the two results that one beat may produce.
    assign qstat.room  = level_reg <= upd_pkg::QCW'(upd_pkg::QDEPTH - 2);
    assign qstat.level = level_reg;

    // Each slot shifts toward the head on a pop and takes new results at the tail.
    always_comb
    begin
        for (int i = 0; i < upd_pkg::QDEPTH; i++) begin
            if (pop && i < upd_pkg::QDEPTH - 1)
                slot_next[i] = slot_reg[i + 1];
            else
                slot_next[i] = slot_reg[i];
            if (emit.count != 2'd0 && base == upd_pkg::QCW'(i))
                slot_next[i] = emit.r0;
            if (emit.count == 2'd2 && base + upd_pkg::QCW'(1) == upd_pkg::QCW'(i))
                slot_next[i] = emit.r1;
        end
        level_next = base + upd_pkg::QCW'(emit.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else
            level_reg <= level_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < upd_pkg::QDEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

endmodule

`default_nettype wire

### sv/url_percent_decoder.sv
// ---------------------------------------------------------------------------
// URL percent decoder
// Streaming percent-decoder for zero-terminated URL strings, one byte a beat.
// ---------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_ready  | in_byte
//  out      | out_valid / out_ready| out_byte, out_position, is_end
//  cfg      | cfg_we               | cfg_wdata (output capacity)
//
// One source beat is accepted every cycle while the result queue has room; the
// decode is one pass of logic between the input register and the result queue.
// A beat's first result passes through the input register and then a queue slot.
// The zero byte inside an escape yields two results; the four-entry queue
// absorbs them, and input stalls only while the queue holds more than two.
// Reset clears the decoder state and sets the capacity to 512; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "url_percent_decoder_macros.svh"

module url_percent_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [15:0]      out_position,
    output logic             is_end
);

    logic             stage_valid;
    logic [7:0]       stage_byte;
    logic             take;
    upd_pkg::emit_t   emit;
    upd_pkg::qstat_t  qstat;
    upd_pkg::result_t head;

    // Input register.
    upd_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    // Decoder.
    upd_decode u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte),
        .qstat       (qstat),
        .take        (take),
        .emit        (emit)
    );

    // Result queue.
    upd_out_queue u_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .qstat     (qstat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte     = head.out_byte;
    assign out_position = head.out_position;
    assign is_end       = head.is_end;

    // Queue never overfills.
    `UPD_ASSERT_IMPL(a_level_max, 1'b1, qstat.level <= upd_pkg::QCW'(upd_pkg::QDEPTH),
        "result queue level above depth")
    // Results are only produced for a taken beat.
    `UPD_ASSERT_IMPL(a_emit_take, emit.count != 2'd0, take, "results without a taken beat")
    // A held beat stays in the input stage while the queue is short of room.
    `UPD_ASSERT_NEXT(a_stall_hold, stage_valid && !qstat.room, stage_valid,
        "held beat lost during stall")
    // Popping the last queued terminator with the input stage empty leaves no result behind.
    `UPD_ASSERT_NEXT(a_end_restart, out_valid && out_ready && is_end && !stage_valid
        && qstat.level == upd_pkg::QCW'(1), !out_valid, "spurious result after terminator")

endmodule

`default_nettype wire
